// ===== design/agpi_pkg.sv =====
// Shared constants for the auto-ranging grip position integrator.
// Holds Q.12 scaling, reset values and register indexes; no dependencies.
package agpi_pkg;

	// Q.12 fixed point: 4096 stands for 1.0
	localparam int QFrac = 12;
	localparam logic [12:0] QOne = 13'd4096;

	// Reset values of the configuration registers
	localparam int RawLimitReset = 500;
	localparam logic [12:0] RestoreForceReset = 13'd1638;
	localparam logic [12:0] StepGainReset = 13'd1229;
	localparam logic [14:0] MinPositionReset = 15'd4096;
	localparam logic [14:0] MaxPositionReset = 15'd16384;

	// Reset values of the per-channel tracking state
	localparam int LowMarkReset = 410;
	localparam int HighMarkReset = 480;
	localparam logic [14:0] PositionReset = 15'd16384;

	// Register indexes (byte address / 4)
	localparam logic [2:0] RegRawLimit = 3'd0;
	localparam logic [2:0] RegRestoreForce = 3'd1;
	localparam logic [2:0] RegStepGain = 3'd2;
	localparam logic [2:0] RegMinPosition = 3'd3;
	localparam logic [2:0] RegMaxPosition = 3'd4;

	// Quotient bits produced by the shared divider
	localparam int QuotBits = 13;

endpackage

// ===== design/autorange_grip_position_integrator_core.sv =====
// Top level of the auto-ranging grip position integrator.
// Depends on agpi_pkg for Q.12 constants, reset values and register indexes.
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+-------------------------------
//  in      | in_valid, in_ready                        | raw_a, raw_b, contact_a/b
//  out     | out_valid, out_ready                      | accepted, force_a/b, pos_a/b
//  config  | psel, penable, pwrite, paddr, pwdata ...  | five registers at 4*index
//
// An accepted pair runs these steps per channel: one step widens the marks, one loads
// the divider, the shared shift-subtract divider then produces the thirteen quotient
// bits, then one each for net force, multiply and clamp; a final step loads the result
// register. A rejected pair goes from acceptance straight to that final step. Reset is
// asynchronous and restores marks, positions and registers.
// A new item is taken as soon as the sequencer is idle, even while the previous result
// waits; the sequencer stalls in its final step only if that result is still not taken.
module autorange_grip_position_integrator_core #(
	parameter int RAW_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [RAW_BITS-1:0] raw_a,
	input  logic [RAW_BITS-1:0] raw_b,
	input  logic [12:0]         contact_a,
	input  logic [12:0]         contact_b,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                accepted,
	output logic [12:0]         force_a,
	output logic [12:0]         force_b,
	output logic [14:0]         pos_a,
	output logic [14:0]         pos_b,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import agpi_pkg::*;

	localparam logic [RAW_BITS-1:0] LimitInit = RAW_BITS'(RawLimitReset);
	localparam logic [RAW_BITS-1:0] LowInit = RAW_BITS'(LowMarkReset);
	localparam logic [RAW_BITS-1:0] HighInit = RAW_BITS'(HighMarkReset);

	typedef enum logic [2:0] {
		StIdle, StMark, StLoad, StDiv, StForce, StMul, StPos, StDone
	} state_t;

	// Configuration registers
	logic [RAW_BITS-1:0] raw_limit_q;
	logic [12:0]         restore_force_q;
	logic [12:0]         step_gain_q;
	logic [14:0]         min_position_q;
	logic [14:0]         max_position_q;

	// Sequencer and per-item working registers
	state_t              state_q;
	logic                ch_q;
	logic [3:0]          cnt_q;
	logic [RAW_BITS-1:0] raw_a_q, raw_b_q;
	logic [12:0]         contact_a_q, contact_b_q;
	logic                pair_ok_q;
	logic [RAW_BITS:0]   rem_q;
	logic [RAW_BITS-1:0] range_q;
	logic                zero_range_q;
	logic [12:0]         quot_q;
	logic signed [15:0]  net_q;
	logic signed [29:0]  prod_q;

	// Tracking state
	logic [RAW_BITS-1:0] low_q [2];
	logic [RAW_BITS-1:0] high_q [2];
	logic [14:0]         position_q [2];
	logic [12:0]         last_force_q [2];

	// Result register
	logic                out_valid_q;
	logic                accepted_q;
	logic [12:0]         force_a_q, force_b_q;
	logic [14:0]         pos_a_q, pos_b_q;

	logic                cfg_write;
	logic [2:0]          reg_index;
	logic                pair_ok;
	logic [RAW_BITS-1:0] raw_ch;
	logic [12:0]         contact_ch;
	logic [RAW_BITS:0]   trial;
	logic                trial_ge;
	logic [RAW_BITS:0]   rem_next;
	logic [12:0]         force_val;
	logic signed [15:0]  net_val;
	logic signed [13:0]  gain_s;
	logic signed [29:0]  prod_val;
	logic signed [17:0]  delta;
	logic signed [17:0]  pos_ext;
	logic signed [17:0]  max_s, min_s;
	logic signed [17:0]  pos_hi_clamped;
	logic [14:0]         pos_new;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_index = paddr[4:2];

	always_comb begin
		unique case (reg_index)
			RegRawLimit:     prdata = 32'(raw_limit_q);
			RegRestoreForce: prdata = 32'(restore_force_q);
			RegStepGain:     prdata = 32'(step_gain_q);
			RegMinPosition:  prdata = 32'(min_position_q);
			RegMaxPosition:  prdata = 32'(max_position_q);
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_limit_q <= LimitInit;
			restore_force_q <= RestoreForceReset;
			step_gain_q <= StepGainReset;
			min_position_q <= MinPositionReset;
			max_position_q <= MaxPositionReset;
		end else if (cfg_write) begin
			unique case (reg_index)
				RegRawLimit:     raw_limit_q <= pwdata[RAW_BITS-1:0];
				RegRestoreForce: restore_force_q <= pwdata[12:0];
				RegStepGain:     step_gain_q <= pwdata[12:0];
				RegMinPosition:  min_position_q <= pwdata[14:0];
				RegMaxPosition:  max_position_q <= pwdata[14:0];
				default:         ;
			endcase
		end
	end

	assign in_ready = (state_q == StIdle);
	assign pair_ok = (raw_a <= raw_limit_q) && (raw_b <= raw_limit_q);
	assign raw_ch = ch_q ? raw_b_q : raw_a_q;
	assign contact_ch = ch_q ? contact_b_q : contact_a_q;

	// Shared divider step: the first step compares the plain numerator, which may
	// equal the range; later steps shift the partial remainder left first.
	assign trial = (cnt_q == 4'd0) ? rem_q : {rem_q[RAW_BITS-1:0], 1'b0};
	assign trial_ge = (trial >= {1'b0, range_q});
	assign rem_next = trial_ge ? (trial - {1'b0, range_q}) : trial;

	always_comb begin
		if (zero_range_q) begin
			force_val = QOne;
		end else if (quot_q >= QOne) begin
			force_val = 13'd0;
		end else begin
			force_val = QOne - quot_q;
		end
	end

	assign net_val = $signed({3'b000, force_val}) - $signed({3'b000, restore_force_q})
		- $signed({3'b000, contact_ch});
	assign gain_s = $signed({1'b0, step_gain_q});
	assign prod_val = net_q * gain_s;

	// Taking the upper bits of the product floors towards minus infinity.
	assign delta = prod_q[29:QFrac];
	assign pos_ext = $signed({3'b000, position_q[ch_q]}) - delta;
	assign max_s = $signed({3'b000, max_position_q});
	assign min_s = $signed({3'b000, min_position_q});
	assign pos_hi_clamped = (pos_ext > max_s) ? max_s : pos_ext;
	assign pos_new = (pos_hi_clamped < min_s) ? min_position_q : pos_hi_clamped[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			ch_q <= 1'b0;
			cnt_q <= 4'd0;
			raw_a_q <= '0;
			raw_b_q <= '0;
			contact_a_q <= '0;
			contact_b_q <= '0;
			pair_ok_q <= 1'b0;
			rem_q <= '0;
			range_q <= '0;
			zero_range_q <= 1'b0;
			quot_q <= '0;
			net_q <= '0;
			prod_q <= '0;
			for (int i = 0; i < 2; i++) begin
				low_q[i] <= LowInit;
				high_q[i] <= HighInit;
				position_q[i] <= PositionReset;
				last_force_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
			accepted_q <= 1'b0;
			force_a_q <= '0;
			force_b_q <= '0;
			pos_a_q <= '0;
			pos_b_q <= '0;
		end else begin
			// In the final step the result register is reloaded below instead.
			if (out_valid_q && out_ready && (state_q != StDone)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				StIdle: begin
					if (in_valid) begin
						raw_a_q <= raw_a;
						raw_b_q <= raw_b;
						contact_a_q <= contact_a;
						contact_b_q <= contact_b;
						pair_ok_q <= pair_ok;
						ch_q <= 1'b0;
						state_q <= pair_ok ? StMark : StDone;
					end
				end
				StMark: begin
					if (raw_ch > high_q[ch_q]) begin
						high_q[ch_q] <= raw_ch;
					end
					if (raw_ch < low_q[ch_q]) begin
						low_q[ch_q] <= raw_ch;
					end
					state_q <= StLoad;
				end
				StLoad: begin
					// The marks now enclose the reading, so neither difference wraps.
					rem_q <= {1'b0, raw_ch - low_q[ch_q]};
					range_q <= high_q[ch_q] - low_q[ch_q];
					zero_range_q <= (high_q[ch_q] == low_q[ch_q]);
					cnt_q <= 4'd0;
					state_q <= StDiv;
				end
				StDiv: begin
					rem_q <= rem_next;
					quot_q <= {quot_q[11:0], trial_ge};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(QuotBits - 1)) begin
						state_q <= StForce;
					end
				end
				StForce: begin
					last_force_q[ch_q] <= force_val;
					net_q <= net_val;
					state_q <= StMul;
				end
				StMul: begin
					prod_q <= prod_val;
					state_q <= StPos;
				end
				StPos: begin
					position_q[ch_q] <= pos_new;
					if (ch_q) begin
						state_q <= StDone;
					end else begin
						ch_q <= 1'b1;
						state_q <= StMark;
					end
				end
				StDone: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						accepted_q <= pair_ok_q;
						force_a_q <= last_force_q[0];
						force_b_q <= last_force_q[1];
						pos_a_q <= position_q[0];
						pos_b_q <= position_q[1];
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign accepted = accepted_q;
	assign force_a = force_a_q;
	assign force_b = force_b_q;
	assign pos_a = pos_a_q;
	assign pos_b = pos_b_q;

endmodule

// ===== bench/tb_autorange_grip_position_integrator_core.sv =====
// Self-checking bench for the auto-ranging grip position integrator core.
// Random and directed sample pairs go through a valid/ready driver; a built-in
// predictor checks every result. Depends on agpi_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_autorange_grip_position_integrator_core;
	import agpi_pkg::*;

	localparam int RawBits = 10;

	typedef struct packed {
		logic [RawBits-1:0] raw_a;
		logic [RawBits-1:0] raw_b;
		logic [12:0]        contact_a;
		logic [12:0]        contact_b;
	} grip_sample_t;

	typedef struct packed {
		logic        accepted;
		logic [12:0] force_a;
		logic [12:0] force_b;
		logic [14:0] pos_a;
		logic [14:0] pos_b;
	} grip_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [RawBits-1:0] raw_a = '0;
	logic [RawBits-1:0] raw_b = '0;
	logic [12:0]        contact_a = '0;
	logic [12:0]        contact_b = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               accepted;
	logic [12:0]        force_a;
	logic [12:0]        force_b;
	logic [14:0]        pos_a;
	logic [14:0]        pos_b;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	autorange_grip_position_integrator_core #(.RAW_BITS(RawBits)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_a(raw_a), .raw_b(raw_b), .contact_a(contact_a), .contact_b(contact_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.accepted(accepted), .force_a(force_a), .force_b(force_b),
		.pos_a(pos_a), .pos_b(pos_b),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor copy of the registers and per-finger tracking state.
	logic [RawBits-1:0] cfg_raw_limit = RawBits'(RawLimitReset);
	logic [12:0]        cfg_restore = RestoreForceReset;
	logic [12:0]        cfg_gain = StepGainReset;
	logic [14:0]        cfg_min_pos = MinPositionReset;
	logic [14:0]        cfg_max_pos = MaxPositionReset;
	logic [RawBits-1:0] lo_mark [2] = '{RawBits'(LowMarkReset), RawBits'(LowMarkReset)};
	logic [RawBits-1:0] hi_mark [2] = '{RawBits'(HighMarkReset), RawBits'(HighMarkReset)};
	logic [14:0]        finger_pos [2] = '{PositionReset, PositionReset};
	logic [12:0]        grip_force [2] = '{13'd0, 13'd0};

	grip_sample_t sample_queue [$];
	grip_result_t expected_grip [$];
	grip_sample_t driven_sample;

	logic in_taken = 1'b0;
	int   send_idle_pct = 10;
	int   recv_idle_pct = 64;
	int   holds_asked = 0;
	int   holds_served = 0;
	int   hold_left = 0;
	int   samples_queued = 0;
	int   samples_taken = 0;
	int   results_checked = 0;
	int   rejected_seen = 0;
	int   settings_used = 0;
	int   error_count = 0;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 40)
			$display("MISMATCH at result %0d: %s", results_checked, msg);
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// One finger: widen the marks, normalise the reading, integrate the position.
	function automatic void advance_finger(input int ch, input logic [RawBits-1:0] raw,
			input logic [12:0] contact);
		longint span, offset, quot, grip, net, delta, pos;
		if (raw > hi_mark[ch])
			hi_mark[ch] = raw;
		if (raw < lo_mark[ch])
			lo_mark[ch] = raw;
		span = (hi_mark[ch] >= lo_mark[ch]) ?
			longint'(hi_mark[ch]) - longint'(lo_mark[ch]) : 0;
		offset = (raw >= lo_mark[ch]) ? longint'(raw) - longint'(lo_mark[ch]) : 0;
		quot = (span != 0) ? (offset * longint'(QOne)) / span : 0;
		grip = (quot >= longint'(QOne)) ? 0 : longint'(QOne) - quot;
		grip_force[ch] = 13'(grip);
		net = grip - longint'(cfg_restore) - longint'(contact);
		// Arithmetic shift floors towards minus infinity, as the step requires.
		delta = (net * longint'(cfg_gain)) >>> QFrac;
		pos = longint'(finger_pos[ch]) - delta;
		if (pos > longint'(cfg_max_pos))
			pos = longint'(cfg_max_pos);
		if (pos < longint'(cfg_min_pos))
			pos = longint'(cfg_min_pos);
		finger_pos[ch] = 15'(pos);
	endfunction

	function automatic grip_result_t integrate_grip(input grip_sample_t s);
		grip_result_t r;
		r.accepted = (s.raw_a <= cfg_raw_limit) && (s.raw_b <= cfg_raw_limit);
		if (r.accepted) begin
			advance_finger(0, s.raw_a, s.contact_a);
			advance_finger(1, s.raw_b, s.contact_b);
		end
		r.force_a = grip_force[0];
		r.force_b = grip_force[1];
		r.pos_a = finger_pos[0];
		r.pos_b = finger_pos[1];
		return r;
	endfunction

	// Sender: a new item is offered only once the previous one has gone.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				driven_sample = sample_queue.pop_front();
				in_valid <= 1'b1;
				raw_a <= driven_sample.raw_a;
				raw_b <= driven_sample.raw_b;
				contact_a <= driven_sample.contact_a;
				contact_b <= driven_sample.contact_b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is asked for.
	always @(negedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left <= 400;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		grip_result_t want;
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			want = integrate_grip({raw_a, raw_b, contact_a, contact_b});
			if (!want.accepted)
				rejected_seen++;
			expected_grip.push_back(want);
			samples_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_grip.size() == 0) begin
				report_mismatch("result arrived with no item outstanding");
			end else begin
				want = expected_grip.pop_front();
				check_field("accepted", accepted, want.accepted);
				check_field("force_a", force_a, want.force_a);
				check_field("force_b", force_b, want.force_b);
				check_field("pos_a", pos_a, want.pos_a);
				check_field("pos_b", pos_b, want.pos_b);
			end
			results_checked++;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			RegRawLimit:     cfg_raw_limit = value[RawBits-1:0];
			RegRestoreForce: cfg_restore = value[12:0];
			RegStepGain:     cfg_gain = value[12:0];
			RegMinPosition:  cfg_min_pos = value[14:0];
			RegMaxPosition:  cfg_max_pos = value[14:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic read_reg(input logic [2:0] idx, input longint want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		check_field($sformatf("register %0d readback", idx), prdata, want);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Values may carry bits above the register width; the core keeps the low bits.
	task automatic program_regs(input logic [31:0] limit, input logic [31:0] restore,
			input logic [31:0] gain, input logic [31:0] min_p, input logic [31:0] max_p);
		write_reg(RegRawLimit, limit);
		write_reg(RegRestoreForce, restore);
		write_reg(RegStepGain, gain);
		write_reg(RegMinPosition, min_p);
		write_reg(RegMaxPosition, max_p);
		read_reg(RegRawLimit, cfg_raw_limit);
		read_reg(RegRestoreForce, cfg_restore);
		read_reg(RegStepGain, cfg_gain);
		read_reg(RegMinPosition, cfg_min_pos);
		read_reg(RegMaxPosition, cfg_max_pos);
		settings_used++;
	endtask

	task automatic push_sample(input int ra, input int rb, input int ca, input int cb);
		sample_queue.push_back({RawBits'(ra), RawBits'(rb), 13'(ca), 13'(cb)});
		samples_queued++;
	endtask

	// Mostly readings within the limit so the marks and positions keep moving.
	task automatic push_random_samples(input int count);
		int ra, rb, ca, cb;
		repeat (count) begin
			ra = ($urandom_range(99) < 88) ? $urandom_range(cfg_raw_limit) :
				$urandom_range((1 << RawBits) - 1);
			rb = ($urandom_range(99) < 88) ? $urandom_range(cfg_raw_limit) :
				$urandom_range((1 << RawBits) - 1);
			ca = ($urandom_range(99) < 90) ? $urandom_range(4096) : $urandom_range(8191);
			cb = ($urandom_range(99) < 90) ? $urandom_range(4096) : $urandom_range(8191);
			push_sample(ra, rb, ca, cb);
		end
	endtask

	task automatic wait_drained();
		while (samples_taken != samples_queued || expected_grip.size() != 0)
			@(negedge clk);
		repeat (40)
			@(negedge clk);
	endtask

	task automatic random_settings();
		logic [31:0] lo_pos;
		lo_pos = $urandom_range(12000);
		program_regs($urandom_range(1023, 300), $urandom_range(4096), $urandom_range(4096),
			lo_pos, $urandom_range(32767, lo_pos));
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: readings at and beyond the limit, widened marks, full contacts.
		push_sample(445, 445, 0, 0);
		push_sample(410, 480, 0, 0);
		push_sample(0, 500, 4096, 4096);
		push_sample(500, 0, 0, 8191);
		push_sample(501, 100, 0, 0);
		push_sample(100, 1023, 0, 0);
		push_sample(1023, 1023, 8191, 8191);
		push_sample(250, 250, 0, 0);
		push_sample(500, 500, 8191, 8191);
		wait_drained();

		// Widest settings: large steps drive both fingers into both clamps.
		program_regs(1023, 0, 8191, 0, 32767);
		push_sample(1023, 0, 0, 0);
		push_sample(0, 0, 0, 0);
		push_sample(0, 0, 0, 0);
		push_sample(0, 0, 0, 0);
		push_sample(1023, 1023, 8191, 8191);
		push_sample(1023, 1023, 8191, 8191);
		wait_drained();

		// Crossed clamps, zero limit, and junk above every register width.
		program_regs(32'hFFFF_FC00, 32'hFFFF_F000 | 4096, 32'hABCD_0000 | 4096,
			32'h8000_0000 | 20000, 32'h0F00_0000 | 1000);
		push_sample(0, 0, 4096, 0);
		push_sample(1, 0, 0, 0);
		push_sample(0, 0, 0, 8191);
		wait_drained();

		repeat (2) begin
			random_settings();
			push_random_samples(150);
			wait_drained();
		end

		send_idle_pct = 64;
		recv_idle_pct = 10;
		random_settings();
		push_random_samples(150);
		wait_drained();

		// No idling, and one long hold-off so that the core backs up onto its input.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_settings();
		holds_asked = holds_asked + 1;
		push_random_samples(150);
		wait_drained();

		$display("Covered %0d sample pairs, %0d of them rejected by the limit, under %0d %s",
			samples_taken, rejected_seen, settings_used, "register settings.");
		$display("Checked %0d results with random stalls on both channels and one long hold-off.",
			results_checked);
		if (error_count == 0) begin
			$display("tb_autorange_grip_position_integrator_core: clean");
		end else begin
			$display("tb_autorange_grip_position_integrator_core: errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d results still outstanding.", expected_grip.size());
		$display("tb_autorange_grip_position_integrator_core: errors");
		$finish;
	end

endmodule
